[hdl/u8d_pkg.sv]
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared widths and constants for the streaming UTF-8 decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned CODE_W  = 31;
   localparam int unsigned COUNT_W = 13;
   localparam int unsigned LEFT_W  = 3;

   // character limit of the string, clipped to what the count field holds
   localparam int unsigned MAX_CHARS     = 4096;
   localparam int unsigned CNT_FIELD_MAX = (1 << COUNT_W) - 1;
   localparam int unsigned CNT_LIMIT     =
      (MAX_CHARS < CNT_FIELD_MAX) ? MAX_CHARS : CNT_FIELD_MAX;

   // continuation byte tag in the top two bits
   localparam logic [1:0] CONT_TAG = 2'b10;

endpackage

[hdl/u8d_req_if.sv]
// ----------------------------------------------------------------------------
// u8d_req_if
// Byte channel into the decoder: one string byte per transfer.
// ----------------------------------------------------------------------------
interface u8d_req_if;
   import u8d_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              is_last;

   modport source (output valid, output data_byte, output is_last, input ready);
   modport sink   (input valid, input data_byte, input is_last, output ready);

endinterface

[hdl/u8d_rsp_if.sv]
// ----------------------------------------------------------------------------
// u8d_rsp_if
// Result channel out of the decoder: code points and end-of-string status.
// ----------------------------------------------------------------------------
interface u8d_rsp_if;
   import u8d_pkg::*;

   logic               valid;
   logic               ready;
   logic               has_code;
   logic [CODE_W-1:0]  code_point;
   logic               end_of_string;
   logic [COUNT_W-1:0] char_count;
   logic               error;

   modport source (output valid, output has_code, output code_point,
                   output end_of_string, output char_count, output error,
                   input ready);
   modport sink   (input valid, input has_code, input code_point,
                   input end_of_string, input char_count, input error,
                   output ready);

endinterface

[hdl/utf8_stream_decoder.sv]
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Streaming UTF-8 decoder, one byte per transfer, one result register.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one string byte per transfer, with is_last set on the final
//   byte of each string. rsp carries at most one result per byte: a result
//   appears when a byte completes a valid character (has_code = 1) and always
//   on the last byte (end_of_string = 1, with char_count and error).
//   Bytes that open or continue a group, skipped lead bytes and bytes after a
//   stray continuation byte make no result.
//   Latency: a result is valid on rsp in the cycle after its byte's transfer.
//   Throughput: one byte per cycle unless stalled; the decode step is a single
//   shift-and-or of the accumulator between decoder state and result register.
//   Stall: while rsp holds a result that is not taken, req.ready is low; it
//   rises in the cycle the result is taken, so a taken result and a new byte
//   transfer together.
//   Reset (synchronous, active high) clears the decoder state and drops any
//   pending result. After each last byte the state returns to empty.
// ----------------------------------------------------------------------------
module utf8_stream_decoder (
   input logic    clock,
   input logic    reset,
   u8d_req_if.sink   req,
   u8d_rsp_if.source rsp
);
   import u8d_pkg::*;

   // decoder state
   logic               halted_ff,  halted_in;
   logic [LEFT_W-1:0]  left_ff,    left_in;
   logic [CODE_W-1:0]  acc_ff,     acc_in;
   logic               bad_ff,     bad_in;
   logic [COUNT_W-1:0] count_ff,   count_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               has_code_ff;
   logic [CODE_W-1:0]  code_ff;
   logic               eos_ff;
   logic [COUNT_W-1:0] char_count_ff;
   logic               error_ff;

   logic               xfer;
   logic               have;
   logic [CODE_W-1:0]  code;
   logic               err;
   logic               emit;
   logic [BYTE_W-1:0]  b;

   assign b    = req.data_byte;
   assign xfer = req.valid && req.ready;

   // input side stalls only when a held result is not taken
   assign req.ready = !rsp_valid_ff || rsp.ready;

   // decode one byte against the current group state
   always_comb begin
      halted_in = halted_ff;
      left_in   = left_ff;
      acc_in    = acc_ff;
      bad_in    = bad_ff;
      have      = 1'b0;
      code      = '0;
      if (!halted_ff) begin
         if (left_ff == '0) begin
            if (b[7] == 1'b0) begin
               have = 1'b1;
               code = CODE_W'(b);
            end else if (b[7:6] == CONT_TAG) begin
               halted_in = 1'b1;
            end else if (b[5] == 1'b0) begin
               left_in = LEFT_W'(1); acc_in = CODE_W'(b[4:0]); bad_in = 1'b0;
            end else if (b[4] == 1'b0) begin
               left_in = LEFT_W'(2); acc_in = CODE_W'(b[3:0]); bad_in = 1'b0;
            end else if (b[3] == 1'b0) begin
               left_in = LEFT_W'(3); acc_in = CODE_W'(b[2:0]); bad_in = 1'b0;
            end else if (b[2] == 1'b0) begin
               left_in = LEFT_W'(4); acc_in = CODE_W'(b[1:0]); bad_in = 1'b0;
            end else if (b[1] == 1'b0) begin
               left_in = LEFT_W'(5); acc_in = CODE_W'(b[0]);   bad_in = 1'b0;
            end
            // 0xfe and 0xff fall through and are skipped
         end else begin
            bad_in  = bad_ff || (b[7:6] != CONT_TAG);
            acc_in  = {acc_ff[CODE_W-7:0], b[5:0]};
            left_in = left_ff - LEFT_W'(1);
            if (left_in == '0 && !bad_in) begin
               have = 1'b1;
               code = acc_in;
            end
         end
      end
   end

   // saturating character count and end-of-string status
   always_comb begin
      count_in = count_ff;
      if (have && (count_ff < COUNT_W'(CNT_LIMIT))) begin
         count_in = count_ff + COUNT_W'(1);
      end
      err  = req.is_last && (halted_in || (left_in != '0));
      emit = have || req.is_last;
   end

   // state update on each transfer, cleared after the last byte
   always_ff @(posedge clock) begin
      if (reset) begin
         halted_ff <= 1'b0;
         left_ff   <= '0;
         acc_ff    <= '0;
         bad_ff    <= 1'b0;
         count_ff  <= '0;
      end else if (xfer) begin
         if (req.is_last) begin
            halted_ff <= 1'b0;
            left_ff   <= '0;
            acc_ff    <= '0;
            bad_ff    <= 1'b0;
            count_ff  <= '0;
         end else begin
            halted_ff <= halted_in;
            left_ff   <= left_in;
            acc_ff    <= acc_in;
            bad_ff    <= bad_in;
            count_ff  <= count_in;
         end
      end
   end

   // result valid: load on a producing transfer, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (xfer && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (xfer && emit) begin
         has_code_ff   <= have;
         code_ff       <= code;
         eos_ff        <= req.is_last;
         char_count_ff <= count_in;
         error_ff      <= err;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.has_code      = has_code_ff;
   assign rsp.code_point    = code_ff;
   assign rsp.end_of_string = eos_ff;
   assign rsp.char_count    = char_count_ff;
   assign rsp.error         = error_ff;

endmodule

[tb/utf8_stream_decoder_tb.sv]
// ----------------------------------------------------------------------------
// utf8_stream_decoder_tb
// Drives byte strings into the UTF-8 decoder and checks every result against
// a cycle-free decoder model kept in the bench. Covers group lengths, skipped
// and malformed bytes, stray continuation, truncation, count saturation,
// random well-formed and broken strings, idle gaps and output back-pressure.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_tb;
   import u8d_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [BYTE_W-1:0] octet_type;

   typedef struct {
      logic               has_code;
      logic [CODE_W-1:0]  code_point;
      logic               end_of_string;
      logic [COUNT_W-1:0] char_count;
      logic               error;
   } decode_result_type;

   logic clock;
   logic reset;

   u8d_req_if req_ch ();
   u8d_rsp_if rsp_ch ();

   utf8_stream_decoder dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // decoder model state
   logic [LEFT_W-1:0]  model_left    = '0;
   logic [CODE_W-1:0]  model_acc     = '0;
   logic               model_bad     = 1'b0;
   logic               model_halted  = 1'b0;
   logic [COUNT_W-1:0] model_count   = '0;

   decode_result_type results_due[$];
   decode_result_type taken_due;
   octet_type         string_bytes[$];

   int unsigned bytes_sent    = 0;
   int unsigned mismatches    = 0;
   int unsigned stall_request = 0;
   int unsigned stall_left    = 0;
   bit          steady_flow   = 1'b0;

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // run limit
   initial begin
      #5_000_000;
      $display("%0t: timeout, %0d results still due", $time, results_due.size());
      $display("utf8_stream_decoder verification failed");
      $finish;
   end

   // decode one accepted byte and queue the result it causes, if any
   function automatic void decode_step(octet_type b, logic last);
      logic              have;
      logic [CODE_W-1:0] code;
      decode_result_type res;
      have = 1'b0;
      code = '0;
      if (!model_halted) begin
         if (model_left == 0) begin
            casez (b)
               8'b0???????: begin
                  have = 1'b1;
                  code = CODE_W'(b);
               end
               8'b10??????: model_halted = 1'b1;
               8'b110?????: begin
                  model_left = LEFT_W'(1); model_acc = CODE_W'(b[4:0]);
                  model_bad  = 1'b0;
               end
               8'b1110????: begin
                  model_left = LEFT_W'(2); model_acc = CODE_W'(b[3:0]);
                  model_bad  = 1'b0;
               end
               8'b11110???: begin
                  model_left = LEFT_W'(3); model_acc = CODE_W'(b[2:0]);
                  model_bad  = 1'b0;
               end
               8'b111110??: begin
                  model_left = LEFT_W'(4); model_acc = CODE_W'(b[1:0]);
                  model_bad  = 1'b0;
               end
               8'b1111110?: begin
                  model_left = LEFT_W'(5); model_acc = CODE_W'(b[0]);
                  model_bad  = 1'b0;
               end
               default: ; // 0xfe and 0xff are dropped
            endcase
         end else begin
            if (b[7:6] != CONT_TAG)
               model_bad = 1'b1;
            model_acc  = {model_acc[CODE_W-7:0], b[5:0]};
            model_left = model_left - LEFT_W'(1);
            if (model_left == 0 && !model_bad) begin
               have = 1'b1;
               code = model_acc;
            end
         end
      end

      if (have && model_count < CNT_LIMIT)
         model_count = model_count + COUNT_W'(1);

      if (have || last) begin
         res.has_code      = have;
         res.code_point    = code;
         res.end_of_string = last;
         res.char_count    = model_count;
         res.error         = last && (model_halted || model_left != 0);
         results_due.push_back(res);
      end

      // string done, back to empty
      if (last) begin
         model_left   = '0;
         model_acc    = '0;
         model_bad    = 1'b0;
         model_halted = 1'b0;
         model_count  = '0;
      end
   endfunction

   // one byte transfer, with random idle cycles ahead of it unless steady_flow is set
   task automatic send_byte(input octet_type b, input logic last);
      if (!steady_flow) begin
         while ($urandom_range(0, 99) < 38) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_ch.valid     <= 1'b1;
      req_ch.data_byte <= b;
      req_ch.is_last   <= last;
      do @(posedge clock); while (!req_ch.ready);
      decode_step(b, last);
      bytes_sent++;
   endtask

   // send the collected string, last flag on its final byte
   task automatic send_string;
      foreach (string_bytes[i])
         send_byte(string_bytes[i], i == string_bytes.size() - 1);
      string_bytes.delete();
   endtask

   // append one group of n bytes with random payload, optionally one bad tail
   task automatic add_group(input int n, input bit spoil);
      int         bad_at;
      logic [1:0] tag;
      case (n)
         1:       string_bytes.push_back({1'b0, 7'($urandom)});
         2:       string_bytes.push_back({3'b110, 5'($urandom)});
         3:       string_bytes.push_back({4'b1110, 4'($urandom)});
         4:       string_bytes.push_back({5'b11110, 3'($urandom)});
         5:       string_bytes.push_back({6'b111110, 2'($urandom)});
         default: string_bytes.push_back({7'b1111110, 1'($urandom)});
      endcase
      bad_at = (spoil && n > 1) ? $urandom_range(1, n - 1) : 0;
      for (int i = 1; i < n; i++) begin
         tag = CONT_TAG;
         if (i == bad_at)
            do tag = 2'($urandom); while (tag == CONT_TAG);
         string_bytes.push_back({tag, 6'($urandom)});
      end
   endtask

   // group length, weighted toward ascii
   function automatic int pick_length();
      return ($urandom_range(0, 99) < 40) ? 1 : $urandom_range(2, 6);
   endfunction

   // zero byte alone and a stray continuation as the only byte
   task automatic test_single_byte_strings;
      string_bytes = '{8'h00};
      send_string();
      string_bytes = '{8'h80};
      send_string();
   endtask

   // smallest and largest payloads of several lengths, every group length
   task automatic test_group_extremes;
      string_bytes = '{8'hC0, 8'h80, 8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF};
      send_string();
      string_bytes = '{8'hF0, 8'h9F, 8'h98, 8'h80, 8'hE2, 8'h82, 8'hAC, 8'hF8,
                       8'h80, 8'h80, 8'h80, 8'h80, 8'h7F};
      send_string();
   endtask

   // malformed group dropped whole, 0xfe and 0xff dropped singly
   task automatic test_skipped_bytes;
      string_bytes = '{8'hC3, 8'h41, 8'hFE, 8'hFF, 8'h7F};
      send_string();
   endtask

   // continuation byte in lead position halts the rest of the string
   task automatic test_stray_continuation;
      string_bytes = '{8'h41, 8'hBF, 8'h42};
      send_string();
   endtask

   // string ends inside a group
   task automatic test_truncation;
      string_bytes = '{8'hE2, 8'h82};
      send_string();
   endtask

   // long ascii string, count stops at its limit; no idling on either side
   task automatic test_count_saturation;
      steady_flow = 1'b1;
      for (int i = 0; i < CNT_LIMIT + 4; i++)
         string_bytes.push_back({1'b0, 7'($urandom)});
      send_string();
      steady_flow = 1'b0;
   endtask

   // receiver holds off for a long stretch while bytes keep being offered
   task automatic test_output_stall;
      steady_flow   = 1'b1;
      stall_request = 120;
      for (int i = 0; i < 24; i++)
         add_group(pick_length(), 1'b0);
      send_string();
      steady_flow = 1'b0;
   endtask

   // random strings: mostly well formed, some with one flaw each
   task automatic test_random_strings;
      int unsigned stop_at;
      int          chars;
      int          flaw;
      int          flaw_at;
      int          n;
      stop_at = bytes_sent + 1250;
      while (bytes_sent < stop_at) begin
         chars   = $urandom_range(1, 10);
         flaw    = $urandom_range(0, 99);
         flaw_at = $urandom_range(0, chars - 1);
         if (flaw >= 97) begin
            // raw noise
            repeat ($urandom_range(1, 8))
               string_bytes.push_back(octet_type'($urandom));
         end else begin
            for (int i = 0; i < chars; i++) begin
               n = pick_length();
               if (i == flaw_at && flaw >= 70 && flaw < 78)
                  add_group($urandom_range(2, 6), 1'b1);
               else
                  add_group(n, 1'b0);
               if (i == flaw_at && flaw >= 78 && flaw < 85)
                  string_bytes.push_back({CONT_TAG, 6'($urandom)});
               if (i == flaw_at && flaw >= 85 && flaw < 91)
                  string_bytes.push_back($urandom_range(0, 1) ? 8'hFE : 8'hFF);
            end
            // cut off a final group
            if (flaw >= 91) begin
               n = $urandom_range(2, 6);
               add_group(n, 1'b0);
               repeat ($urandom_range(1, n - 1))
                  void'(string_bytes.pop_back());
            end
         end
         send_string();
      end
   endtask

   // report one field of a result
   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // result side: check each transfer, then choose ready for the next cycle
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (results_due.size() == 0) begin
            $display("%0t: result with nothing due, code_point %h, end %b", $time,
                     rsp_ch.code_point, rsp_ch.end_of_string);
            mismatches++;
         end else begin
            taken_due = results_due.pop_front();
            check_field("has_code", 32'(taken_due.has_code), 32'(rsp_ch.has_code));
            check_field("code_point", 32'(taken_due.code_point),
                        32'(rsp_ch.code_point));
            check_field("end_of_string", 32'(taken_due.end_of_string),
                        32'(rsp_ch.end_of_string));
            check_field("char_count", 32'(taken_due.char_count),
                        32'(rsp_ch.char_count));
            check_field("error", 32'(taken_due.error), 32'(rsp_ch.error));
         end
      end

      if (stall_request != 0) begin
         stall_left    = stall_request;
         stall_request = 0;
      end
      if (stall_left != 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else if (steady_flow) begin
         rsp_ch.ready <= 1'b1;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= 38);
      end
   end

   // main sequence
   initial begin
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.data_byte = '0;
      req_ch.is_last   = 1'b0;
      rsp_ch.ready     = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_single_byte_strings();
      test_group_extremes();
      test_skipped_bytes();
      test_stray_continuation();
      test_truncation();
      test_count_saturation();
      test_output_stall();
      test_random_strings();

      // drain and settle
      req_ch.valid <= 1'b0;
      while (results_due.size() != 0)
         @(posedge clock);
      repeat (5) @(posedge clock);

      if (mismatches == 0)
         $display("utf8_stream_decoder verification clean");
      else
         $display("utf8_stream_decoder verification failed");
      $finish;
   end

endmodule
